// ----- rtl/slrwl_pkg.sv -----
// Shared types and constants of the scanline register write list.
// Used by the channel interfaces, the core and its checker; depends on nothing.
`default_nettype none

package slrwl_pkg;

  localparam int EntriesPerBank = 4;
  localparam int OpW            = 2;
  localparam int LineW          = 8;
  localparam int AddrW          = 32;
  localparam int DataW          = 16;

  // Line code that never matches a display line.
  localparam logic [LineW-1:0] LineDisabled = 8'hff;

  typedef enum logic [OpW-1:0] {
    OpEvent  = 2'd0,
    OpInsert = 2'd1,
    OpSwap   = 2'd2
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [LineW-1:0] line;
    logic [AddrW-1:0] target_address;
    logic [DataW-1:0] write_value;
  } in_t;

  typedef struct packed {
    logic             write_valid;
    logic [AddrW-1:0] write_address;
    logic [DataW-1:0] write_data;
    logic [LineW-1:0] compare_line;
    logic             last;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/slrwl_if.sv -----
// Valid/ready channel interfaces for the input items and the result beats.
// Depends on slrwl_pkg for the payload structs.
`default_nettype none

interface slrwl_in_if;
  logic            valid;
  logic            ready;
  slrwl_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slrwl_out_if;
  logic            valid;
  logic            ready;
  slrwl_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/scanline_register_write_list_core.sv -----
// Latency: the first result beat is valid the cycle after its item is accepted.
// Throughput: an insert gives one beat, a line event one beat per matching entry
// (up to ENTRIES_PER_BANK), one per cycle while out_o.ready is high; the next item is
// taken with the last beat. Swaps, full-bank inserts and unmatched events give none.
// Reset (async, active low): bank 0 active, both banks empty, all lines 0xff;
// ready is high at once, also while reset is held; no clearing sweep.
`default_nettype none

module scanline_register_write_list_core #(
  parameter int ENTRIES_PER_BANK = slrwl_pkg::EntriesPerBank
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  slrwl_in_if.sink     in_i,
  slrwl_out_if.source  out_o
);

  localparam int N     = ENTRIES_PER_BANK;
  localparam int IdxW  = (N > 1) ? $clog2(N) : 1;
  localparam int FillW = $clog2(N + 1);

  // Entry stores, one row per bank. Lines reset to disabled; address and value
  // are only read once written.
  logic [slrwl_pkg::LineW-1:0] entry_line_q [2][N];
  logic [slrwl_pkg::LineW-1:0] entry_line_d [2][N];
  logic [slrwl_pkg::AddrW-1:0] entry_addr_q [2][N];
  logic [slrwl_pkg::AddrW-1:0] entry_addr_d [2][N];
  logic [slrwl_pkg::DataW-1:0] entry_val_q  [2][N];
  logic [slrwl_pkg::DataW-1:0] entry_val_d  [2][N];
  logic [FillW-1:0]            fill_q       [2];
  logic [FillW-1:0]            fill_d       [2];
  logic                        act_q, act_d;

  // Result register and the matches still to be sent for the current event.
  logic                        res_valid_q, res_valid_d;
  logic [N-1:0]                pend_q, pend_d;
  slrwl_pkg::out_t             res_q, res_d;

  logic                        back;
  logic                        in_ready;
  logic                        take;
  logic                        adv;
  logic [N-1:0]                ev_mask;
  logic [N-1:0]                sel_mask;
  logic [N-1:0]                rest;
  logic [IdxW-1:0]             sel_idx;
  logic [IdxW-1:0]             nx_idx;
  logic [IdxW-1:0]             ins_idx;
  logic                        load_entry;
  logic                        load_ins;

  always_comb begin
    back     = ~act_q;
    // Take a new item when the result register is free or sends its last beat.
    in_ready = !res_valid_q || (out_o.ready && res_q.last);
    take     = in_i.valid && in_ready;
    adv      = res_valid_q && out_o.ready;

    // Compare the event line against every active entry; disabled never matches.
    for (int i = 0; i < N; i++) begin
      ev_mask[i] = (entry_line_q[act_q][i] != slrwl_pkg::LineDisabled) &&
                   (entry_line_q[act_q][i] == in_i.data.line);
    end

    // Pick the lowest pending match, from a new event or from what is left.
    sel_mask = (take && (in_i.data.operation == slrwl_pkg::OpEvent)) ? ev_mask : pend_q;
    sel_idx  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (sel_mask[i]) begin
        sel_idx = IdxW'(i);
      end
    end
    for (int i = 0; i < N; i++) begin
      rest[i] = sel_mask[i] && (IdxW'(i) != sel_idx);
    end
    // Line compare moves to the following entry, wrapping to the first.
    nx_idx  = (sel_idx == IdxW'(N - 1)) ? '0 : sel_idx + IdxW'(1);
    ins_idx = fill_q[back][IdxW-1:0];

    entry_line_d = entry_line_q;
    entry_addr_d = entry_addr_q;
    entry_val_d  = entry_val_q;
    fill_d       = fill_q;
    act_d        = act_q;
    res_valid_d  = res_valid_q;
    pend_d       = pend_q;
    load_entry   = 1'b0;
    load_ins     = 1'b0;

    // Drop the result once its last beat leaves.
    if (adv && res_q.last) begin
      res_valid_d = 1'b0;
    end

    if (take) begin
      case (in_i.data.operation)
        slrwl_pkg::OpEvent: begin
          if (|ev_mask) begin
            res_valid_d = 1'b1;
            load_entry  = 1'b1;
            pend_d      = rest;
          end
        end
        slrwl_pkg::OpInsert: begin
          // Append to the back bank; ignore once it is full.
          if (fill_q[back] < FillW'(N)) begin
            entry_line_d[back][ins_idx] = in_i.data.line;
            entry_addr_d[back][ins_idx] = in_i.data.target_address;
            entry_val_d[back][ins_idx]  = in_i.data.write_value;
            fill_d[back]                = fill_q[back] + FillW'(1);
            res_valid_d                 = 1'b1;
            load_ins                    = 1'b1;
            pend_d                      = '0;
          end
        end
        slrwl_pkg::OpSwap: begin
          // Disable and empty the active bank, then flip banks.
          for (int i = 0; i < N; i++) begin
            entry_line_d[act_q][i] = slrwl_pkg::LineDisabled;
          end
          fill_d[act_q] = '0;
          act_d         = back;
        end
        default: begin
        end
      endcase
    end else if (adv && !res_q.last) begin
      // Advance to the next matching entry of the same event.
      load_entry = 1'b1;
      pend_d     = rest;
    end

    res_d = res_q;
    if (load_entry) begin
      res_d.write_valid   = 1'b1;
      res_d.write_address = entry_addr_q[act_q][sel_idx];
      res_d.write_data    = entry_val_q[act_q][sel_idx];
      res_d.compare_line  = entry_line_q[act_q][nx_idx];
      res_d.last          = !(|rest);
    end else if (load_ins) begin
      res_d.write_valid   = 1'b0;
      res_d.write_address = '0;
      res_d.write_data    = '0;
      res_d.compare_line  = in_i.data.line;
      res_d.last          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < N; i++) begin
          entry_line_q[b][i] <= slrwl_pkg::LineDisabled;
        end
        fill_q[b] <= '0;
      end
      act_q       <= 1'b0;
      res_valid_q <= 1'b0;
      pend_q      <= '0;
    end else begin
      entry_line_q <= entry_line_d;
      fill_q       <= fill_d;
      act_q        <= act_d;
      res_valid_q  <= res_valid_d;
      pend_q       <= pend_d;
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk_i) begin
    entry_addr_q <= entry_addr_d;
    entry_val_q  <= entry_val_d;
    res_q        <= res_d;
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

endmodule

`default_nettype wire

// ----- rtl/slrwl_checker.sv -----
// Port-level assertions for scanline_register_write_list_core, attached by bind.
// Depends on slrwl_pkg for field widths.
`default_nettype none

module slrwl_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_ready_i,
  input wire                              out_valid_i,
  input wire                              out_ready_i,
  input wire                              out_write_valid_i,
  input wire [slrwl_pkg::AddrW-1:0]       out_write_address_i,
  input wire [slrwl_pkg::DataW-1:0]       out_write_data_i,
  input wire [slrwl_pkg::LineW-1:0]       out_compare_line_i,
  input wire                              out_last_i
);

  // Hold a stalled beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_write_valid_i) &&
      $stable(out_write_address_i) && $stable(out_write_data_i) &&
      $stable(out_compare_line_i) && $stable(out_last_i))
    else $error("stalled result beat changed");

  // Take no item while a result sequence is still unfinished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || (out_ready_i && out_last_i))
    else $error("item accepted in the middle of a result sequence");

  // An insert acknowledge is a single, empty beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_write_valid_i |->
      out_last_i && (out_write_address_i == '0) && (out_write_data_i == '0))
    else $error("malformed insert acknowledge");

  // A non-final beat is followed at once by another triggered write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_write_valid_i)
    else $error("result sequence broken off");

endmodule

bind scanline_register_write_list_core slrwl_checker u_slrwl_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_write_valid_i   (out_o.data.write_valid),
  .out_write_address_i (out_o.data.write_address),
  .out_write_data_i    (out_o.data.write_data),
  .out_compare_line_i  (out_o.data.compare_line),
  .out_last_i          (out_o.data.last)
);

`default_nettype wire
